/* sv/ssim_pkg.sv */
package ssim_pkg;

  localparam int MASK_W    = 32;
  localparam int RES_CNT_W = 7;

  typedef struct packed {
    logic [MASK_W-1:0] side_a_mask;
    logic [MASK_W-1:0] side_b_mask;
    logic              batch_end;
  } split_in_t;

  typedef struct packed {
    logic                 added;
    logic [RES_CNT_W-1:0] removed_count;
    logic [RES_CNT_W-1:0] entries_held;
    logic                 overflow;
    logic                 batch_changed;
  } split_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMPACT,
    S_APPEND,
    S_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic compact;
    logic restart;
    logic append;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic drain;
    logic out_free;
  } dp_sts_t;

  // does split (pa, pb) imply split (qa, qb)
  function automatic logic split_implies(input logic [MASK_W-1:0] pa,
                                         input logic [MASK_W-1:0] pb,
                                         input logic [MASK_W-1:0] qa,
                                         input logic [MASK_W-1:0] qb);
    logic straight;
    logic crossed;
    straight = ((qa & ~pa) == '0) && ((qb & ~pb) == '0);
    crossed  = ((qb & ~pa) == '0) && ((qa & ~pb) == '0);
    return straight || crossed;
  endfunction

endpackage

/* sv/ssim_ctrl.sv */
module ssim_ctrl
  import ssim_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (sts.hit) begin
          state_nxt = S_FINISH;
        end else if (sts.drain) begin
          cmd.restart = 1'b1;
          state_nxt   = S_COMPACT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_COMPACT: begin
        cmd.compact = 1'b1;
        if (sts.drain) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/ssim_dpath.sv */
module ssim_dpath
  import ssim_pkg::*;
#(
  parameter int TAXA     = 32,
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  split_in_t  in_data,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic       out_valid,
  output split_res_t out_data,
  input  logic       out_stall
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);
  localparam logic [MASK_W-1:0] TaxaMask =
    (TAXA >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << TAXA) - 64'd1);

  logic [MASK_W-1:0] mem_a [CAPACITY];
  logic [MASK_W-1:0] mem_b [CAPACITY];

  logic [MASK_W-1:0] new_a_r, new_a_nxt, new_b_r, new_b_nxt;
  logic              last_r, last_nxt;
  logic [MASK_W-1:0] rd_a_r, rd_b_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]  removed_r, removed_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic              added_r, added_nxt;
  logic              overflow_r, overflow_nxt;
  logic              batch_r, batch_nxt;
  logic              out_valid_r, out_valid_nxt;
  split_res_t        out_data_r, out_data_nxt;

  logic              rd_en, wr_en, keep_en, drop_en, changed;
  logic [MASK_W-1:0] wr_a, wr_b;
  logic [CNT_W+RES_CNT_W-1:0] removed_ext, count_ext;

  assign rd_en   = (cmd.scan || cmd.compact) && !cmd.restart && (rd_idx_r != count_r);
  assign drop_en = cmd.compact && rvalid_r && split_implies(new_a_r, new_b_r, rd_a_r, rd_b_r);
  assign keep_en = cmd.compact && rvalid_r && !drop_en;
  assign wr_en   = keep_en || (cmd.append && (wr_idx_r != CapCnt));
  assign wr_a    = keep_en ? rd_a_r : new_a_r;
  assign wr_b    = keep_en ? rd_b_r : new_b_r;

  assign sts.hit      = rvalid_r && split_implies(rd_a_r, rd_b_r, new_a_r, new_b_r);
  assign sts.drain    = (rd_idx_r == count_r) && !rvalid_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign changed     = batch_r | added_r;
  assign removed_ext = {{RES_CNT_W{1'b0}}, removed_r};
  assign count_ext   = {{RES_CNT_W{1'b0}}, count_r};

  // split table, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem_a[rd_idx_r[IDX_W-1:0]];
      rd_b_r <= mem_b[rd_idx_r[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem_a[wr_idx_r[IDX_W-1:0]] <= wr_a;
      mem_b[wr_idx_r[IDX_W-1:0]] <= wr_b;
    end
  end

  always_comb begin
    new_a_nxt     = new_a_r;
    new_b_nxt     = new_b_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    removed_nxt   = removed_r;
    rvalid_nxt    = rvalid_r;
    added_nxt     = added_r;
    overflow_nxt  = overflow_r;
    batch_nxt     = batch_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cmd.load) begin
      new_a_nxt    = in_data.side_a_mask & TaxaMask;
      new_b_nxt    = in_data.side_b_mask & TaxaMask;
      last_nxt     = in_data.batch_end;
      rd_idx_nxt   = '0;
      wr_idx_nxt   = '0;
      removed_nxt  = '0;
      rvalid_nxt   = 1'b0;
      added_nxt    = 1'b0;
      overflow_nxt = 1'b0;
    end

    if (cmd.scan || cmd.compact) begin
      rvalid_nxt = rd_en;
      if (rd_en) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
    end
    if (keep_en) begin
      wr_idx_nxt = wr_idx_r + 1'b1;
    end
    if (drop_en) begin
      removed_nxt = removed_r + 1'b1;
    end

    if (cmd.restart) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      rvalid_nxt = 1'b0;
    end

    if (cmd.append) begin
      if (wr_idx_r != CapCnt) begin
        count_nxt = wr_idx_r + 1'b1;
        added_nxt = 1'b1;
      end else begin
        count_nxt    = wr_idx_r;
        overflow_nxt = 1'b1;
      end
    end

    if (cmd.finish) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.added         = added_r;
      out_data_nxt.removed_count = removed_ext[RES_CNT_W-1:0];
      out_data_nxt.entries_held  = count_ext[RES_CNT_W-1:0];
      out_data_nxt.overflow      = overflow_r;
      out_data_nxt.batch_changed = changed;
      batch_nxt                  = last_r ? 1'b0 : changed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      removed_r   <= '0;
      rvalid_r    <= 1'b0;
      added_r     <= 1'b0;
      overflow_r  <= 1'b0;
      batch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      removed_r   <= removed_nxt;
      rvalid_r    <= rvalid_nxt;
      added_r     <= added_nxt;
      overflow_r  <= overflow_nxt;
      batch_r     <= batch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_a_r    <= new_a_nxt;
    new_b_r    <= new_b_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CapCnt)
    else $error("entry count above capacity");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= rd_idx_r)
    else $error("compaction write passed read pointer");

  a_overflow_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.append && (wr_idx_r == CapCnt)) |-> (removed_r == '0))
    else $error("overflow raised after removals");

  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !(out_data_r.added && out_data_r.overflow))
    else $error("split both added and overflowed");
`endif

endmodule

/* sv/split_set_implication_merge_top.sv */
// Split table with implication merge. Each input beat carries one split (side A
// and side B taxon masks, bits at or above TAXA ignored) and a batch end mark,
// and yields exactly one result beat. A split implied by any stored split is
// dropped; otherwise every stored split it implies is removed in order and the
// new split is appended, or overflow is flagged when the table is full and
// nothing was removed. batch_changed ORs added over the batch up to and
// including the beat marked batch_end. The table sits in a single memory with
// one read and one write port, so an item takes two passes over the stored
// entries: an implication scan and then compaction, then an append step and a
// result load step. A stored split that implies the new one ends the scan
// early and skips compaction and append. One item is in flight at a time;
// the result register lets the next beat enter while a result waits on
// out_stall, and the result load of that next item waits until the register
// is free. Reset clears the entry count and batch flag, no memory sweep is
// needed since only entries below the count are read.
module split_set_implication_merge_top
  import ssim_pkg::*;
#(
  parameter int TAXA     = 32,
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  split_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output split_res_t out_data
);

  // command and status between controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: scan, compact, append, deliver
  ssim_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table memory, pointers, counters and result register
  ssim_dpath #(
    .TAXA     (TAXA),
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

/* bench/testbench.sv */
module testbench;
  import ssim_pkg::*;

  localparam int TAXA        = 32;
  localparam int CAPACITY    = 64;
  localparam logic [MASK_W-1:0] TAXA_MASK =
    (TAXA >= MASK_W) ? '1 : ((MASK_W'(1) << TAXA) - 1);
  localparam int NUM_DIR     = 15;
  localparam int PHASE_BEATS = 96;
  localparam int DRAIN_WAIT  = 200;
  localparam int CYCLE_LIMIT = 500000;

  // directed row: stimulus, whether the result is typed in, and that result
  typedef struct packed {
    logic [MASK_W-1:0] a;
    logic [MASK_W-1:0] b;
    logic              last;
    logic              fixed;
    split_res_t        res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  split_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  split_res_t out_data;

  // shadow copy of the split table, kept in step with accepted beats
  logic [MASK_W-1:0] tbl_a [CAPACITY];
  logic [MASK_W-1:0] tbl_b [CAPACITY];
  int                tbl_held = 0;
  logic              batch_open = 1'b0;

  split_res_t pending_results[$];
  split_res_t want;
  dir_row_t   dir_rows [NUM_DIR];
  int         mismatches = 0;
  int         results_seen = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;

  split_set_implication_merge_top #(
    .TAXA     (TAXA),
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // p covers q when q's sides fit inside p's, straight or crossed
  function automatic logic split_covers(input logic [MASK_W-1:0] pa,
                                        input logic [MASK_W-1:0] pb,
                                        input logic [MASK_W-1:0] qa,
                                        input logic [MASK_W-1:0] qb);
    return (((qa & ~pa) == '0) && ((qb & ~pb) == '0)) ||
           (((qb & ~pa) == '0) && ((qa & ~pb) == '0));
  endfunction

  // apply one split to the shadow table and return the result beat it gives
  function automatic split_res_t merge_split(input split_in_t item);
    logic [MASK_W-1:0] na;
    logic [MASK_W-1:0] nb;
    logic              hit;
    int                i;
    int                keep;
    int                removed;
    split_res_t        r;
    na      = item.side_a_mask & TAXA_MASK;
    nb      = item.side_b_mask & TAXA_MASK;
    hit     = 1'b0;
    removed = 0;
    r       = '0;
    for (i = 0; i < tbl_held; i++) begin
      if (split_covers(tbl_a[i], tbl_b[i], na, nb)) hit = 1'b1;
    end
    if (!hit) begin
      // drop every stored split the new one covers, survivors slide down
      keep = 0;
      for (i = 0; i < tbl_held; i++) begin
        if (split_covers(na, nb, tbl_a[i], tbl_b[i])) begin
          removed++;
        end else begin
          tbl_a[keep] = tbl_a[i];
          tbl_b[keep] = tbl_b[i];
          keep++;
        end
      end
      tbl_held = keep;
      if (tbl_held < CAPACITY) begin
        tbl_a[tbl_held] = na;
        tbl_b[tbl_held] = nb;
        tbl_held++;
        r.added = 1'b1;
      end else begin
        r.overflow = 1'b1;
      end
    end
    r.removed_count = RES_CNT_W'(removed);
    r.entries_held  = RES_CNT_W'(tbl_held);
    r.batch_changed = batch_open | r.added;
    batch_open      = item.batch_end ? 1'b0 : r.batch_changed;
    return r;
  endfunction

  // random split, mostly shaped against what the table holds right now
  function automatic split_in_t pick_split();
    split_in_t         s;
    logic [MASK_W-1:0] a;
    logic [MASK_W-1:0] b;
    int                kind;
    int                i;
    int                j;
    int                r;
    kind = $urandom_range(99);
    a    = '0;
    b    = '0;
    if (tbl_held == 0 && kind >= 45 && kind < 87) kind = 0;
    if (kind < 45) begin
      // fresh sparse split with disjoint sides
      for (i = 0; i < MASK_W; i++) begin
        r = $urandom_range(15);
        if (r < 3) a[i] = 1'b1;
        else if (r < 6) b[i] = 1'b1;
      end
    end else if (kind < 65) begin
      // grows a stored split so it removes that entry
      i = $urandom_range(tbl_held - 1);
      a = tbl_a[i] | ($urandom & $urandom & $urandom);
      b = tbl_b[i] | ($urandom & $urandom & $urandom);
    end else if (kind < 80) begin
      // shrinks a stored split so it gets dropped as implied
      i = $urandom_range(tbl_held - 1);
      a = tbl_a[i] & $urandom;
      b = tbl_b[i] & $urandom;
    end else if (kind < 87) begin
      // union of two stored splits, second one maybe crossed
      i = $urandom_range(tbl_held - 1);
      j = $urandom_range(tbl_held - 1);
      if ($urandom_range(1) == 1) begin
        a = tbl_a[i] | tbl_b[j];
        b = tbl_b[i] | tbl_a[j];
      end else begin
        a = tbl_a[i] | tbl_a[j];
        b = tbl_b[i] | tbl_b[j];
      end
    end else if (kind < 93) begin
      // noise, sides overlap freely
      a = $urandom;
      b = $urandom;
    end else begin
      // one-sided or empty split
      a = ($urandom_range(1) == 1) ? ($urandom & $urandom & $urandom) : '0;
    end
    if ($urandom_range(1) == 1) {a, b} = {b, a};
    s.side_a_mask = a;
    s.side_b_mask = b;
    s.batch_end   = ($urandom_range(5) == 0);
    return s;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // present one beat at the falling edge after random idle cycles, hold it
  // until accepted, then queue what it should give
  task automatic send_split(input split_in_t item, input logic fixed,
                            input split_res_t fixed_res);
    split_res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = merge_split(item);
    pending_results.insert(pending_results.size(), fixed ? fixed_res : predicted);
  endtask

  // receiver side stall pattern, changes at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result beats, each against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d with nothing pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (out_data.added !== want.added)
          flag_mismatch($sformatf("beat %0d added %b, want %b",
                                  results_seen, out_data.added, want.added));
        if (out_data.removed_count !== want.removed_count)
          flag_mismatch($sformatf("beat %0d removed_count %0d, want %0d", results_seen,
                                  out_data.removed_count, want.removed_count));
        if (out_data.entries_held !== want.entries_held)
          flag_mismatch($sformatf("beat %0d entries_held %0d, want %0d", results_seen,
                                  out_data.entries_held, want.entries_held));
        if (out_data.overflow !== want.overflow)
          flag_mismatch($sformatf("beat %0d overflow %b, want %b",
                                  results_seen, out_data.overflow, want.overflow));
        if (out_data.batch_changed !== want.batch_changed)
          flag_mismatch($sformatf("beat %0d batch_changed %b, want %b", results_seen,
                                  out_data.batch_changed, want.batch_changed));
      end
      results_seen++;
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int        k;
    int        ph;
    split_in_t item;

    // fields: a, b, batch end, typed, {added, removed, held, overflow, changed}
    // empty split into an empty table is appended
    dir_rows[0]  = {32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
                    {1'b1, 7'd0, 7'd1, 1'b0, 1'b1}};
    // empty split again, now implied by the stored one
    dir_rows[1]  = {32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
                    {1'b0, 7'd0, 7'd1, 1'b0, 1'b1}};
    // all taxa on side a, replaces the empty split
    dir_rows[2]  = {32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
                    {1'b1, 7'd1, 7'd1, 1'b0, 1'b1}};
    // crossed copy is implied, closes the batch
    dir_rows[3]  = {32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
                    {1'b0, 7'd0, 7'd1, 1'b0, 1'b1}};
    // dropped in a one-beat batch, so nothing changed
    dir_rows[4]  = {32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
                    {1'b0, 7'd0, 7'd1, 1'b0, 1'b0}};
    dir_rows[5]  = {32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1,
                    {1'b1, 7'd1, 7'd1, 1'b0, 1'b1}};
    // overlapping sides, then its crossed twin, then one that covers it crossed
    dir_rows[6]  = {32'h0000_00F0, 32'h0000_0030, 1'b0, 1'b0, 17'd0};
    dir_rows[7]  = {32'h0000_0030, 32'h0000_00F0, 1'b0, 1'b0, 17'd0};
    dir_rows[8]  = {32'h0000_0070, 32'h0000_00F0, 1'b0, 1'b0, 17'd0};
    // two small splits, then one that removes both
    dir_rows[9]  = {32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0, 17'd0};
    dir_rows[10] = {32'h0004_0000, 32'h0008_0000, 1'b0, 1'b0, 17'd0};
    dir_rows[11] = {32'h0005_0000, 32'h000A_0000, 1'b1, 1'b0, 17'd0};
    // top taxa, and a one-sided split under it
    dir_rows[12] = {32'h8000_0000, 32'h4000_0000, 1'b0, 1'b0, 17'd0};
    dir_rows[13] = {32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 17'd0};
    // alternating full bipartition sweeps up several entries
    dir_rows[14] = {32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 17'd0};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < NUM_DIR; k++) begin
      item.side_a_mask = dir_rows[k].a;
      item.side_b_mask = dir_rows[k].b;
      item.batch_end   = dir_rows[k].last;
      send_split(item, dir_rows[k].fixed, dir_rows[k].res);
    end

    // phases: no idling, sender idle, receiver stalling, both
    for (ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        // hold off until every pending result is back
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      send_idle_pct = (ph == 1) ? 78 : (ph == 3) ? 36 : 0;
      stall_pct     = (ph == 2) ? 78 : (ph == 3) ? 36 : 0;
      for (k = 0; k < PHASE_BEATS; k++) begin
        send_split(pick_split(), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/ssim_pkg.sv
sv/ssim_ctrl.sv
sv/ssim_dpath.sv
sv/split_set_implication_merge_top.sv
bench/testbench.sv
